// ===== design/etih_pkg.sv =====
// Shared types and constants for the event time interval histogram.
// No dependencies; imported by event_time_interval_histogram_unit.
package etih_pkg;

  localparam int TIME_W   = 32;
  localparam int WIDTH_W  = 32;
  localparam int NBINS_W  = 7;
  localparam int COUNT_W  = 24;
  localparam int IDX_W    = 6;
  localparam int CFG_W    = 32;
  localparam int PADDR_W  = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // register indexes, taken from paddr[2]
  localparam logic REG_BIN_WIDTH   = 1'b0;
  localparam logic REG_BINS_IN_USE = 1'b1;

  localparam logic [WIDTH_W-1:0] WIDTH_RST = 32'd1;
  localparam logic [NBINS_W-1:0] NBINS_RST = 7'd64;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_WRITE,
    ST_DUMP_RD,
    ST_DUMP_WR
  } etih_state_t;

endpackage

// ===== design/event_time_interval_histogram_unit.sv =====
// Event time interval histogram: counts ascending timestamps into fixed-width bins.
// Bin counts live in one synchronous RAM; depends on etih_pkg.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  s_tdata = timestamp, s_tlast = last_event
//  m_*      out  m_tvalid / m_tready  m_tdata = bin_index, bin_count; m_tlast = last_bin;
//                                     m_tuser = events_dropped
//  apb      cfg  psel & penable       0x0 bin_width, 0x4 bins_in_use
//
// An ordinary event passes through a RAM read, then a saturating write back, with one
// more evaluation step for each bin boundary the pointer steps over; the 39-bit boundary add sets that.
// An event marked last is followed by a readout that reads and then writes each bin swept, the sweep
// running over the bins in use and any higher bin the pointer reached (cleared as read).
// After reset a clearing pass over all MAX_BINS bins zeroes the RAM; no item is taken then.
// The result register lets the next event in while the final bin still waits on m_tready.
module event_time_interval_histogram_unit
  import etih_pkg::*;
#(
  parameter int MAX_BINS = 64
) (
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TIME_W-1:0]  s_tdata,   // [31:0] timestamp
  input  logic               s_tlast,   // last_event
  // result items
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,   // [5:0] bin_index, [29:6] bin_count, [31:30] zero
  output logic               m_tlast,   // last_bin
  output logic               m_tuser,   // [0] events_dropped
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]   pwdata,
  output logic [CFG_W-1:0]   prdata,
  output logic               pready
);

  localparam int ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CUR_W  = $clog2(MAX_BINS + 1);     // pointer may sit at MAX_BINS
  localparam int MUL_W  = $clog2(MAX_BINS + 2);     // holds pointer + 1
  localparam int END_W  = WIDTH_W + MUL_W;          // bin_width * (pointer + 1)
  localparam int CMP_W  = (CUR_W > NBINS_W) ? CUR_W : NBINS_W;
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAX_BINS - 1);

  // ---------------------------------------------------------------- registers
  etih_state_t         state, state_next;
  logic [WIDTH_W-1:0]  bin_width;
  logic [NBINS_W-1:0]  bins_in_use;
  logic [CUR_W-1:0]    cur;          // bin pointer
  logic [END_W-1:0]    bin_end;      // end time of current bin, inclusive
  logic                dropped;
  logic [TIME_W-1:0]   ev_time;
  logic                ev_last;
  logic                do_inc;       // event lands in a bin, not dropped
  logic [ADDR_W-1:0]   sweep;        // clear / readout address
  logic [ADDR_W-1:0]   sweep_last;

  logic [COUNT_W-1:0]  mem [MAX_BINS];
  logic [COUNT_W-1:0]  rd_data;

  logic                out_valid;
  logic [IDX_W-1:0]    out_index;
  logic [COUNT_W-1:0]  out_count;
  logic                out_last;
  logic                out_drop;

  // ---------------------------------------------------------------- decode
  logic [CUR_W-1:0]    n_active;
  logic                step;
  logic                in_acc;
  logic                cfg_wr;
  logic                emit;
  logic                out_free;
  logic [CUR_W-1:0]    cur_clip;
  logic [CUR_W-1:0]    n_last;
  logic [MUL_W-1:0]    cur_p1;

  logic                rd_en, wr_en, out_load;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  logic [COUNT_W-1:0]  wr_data;

  // bins in use: 0 acts as 1, above MAX_BINS acts as MAX_BINS
  always_comb begin
    if (bins_in_use == '0) begin
      n_active = CUR_W'(1);
    end else if (CMP_W'(bins_in_use) > CMP_W'(MAX_BINS)) begin
      n_active = CUR_W'(MAX_BINS);
    end else begin
      n_active = CUR_W'(bins_in_use);
    end
  end

  assign step     = (cur < n_active) && (END_W'(ev_time) > bin_end);
  assign in_acc   = s_tvalid && s_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign emit     = CUR_W'(sweep) < n_active;
  assign out_free = !out_valid || m_tready;
  assign cur_p1   = MUL_W'(cur) + MUL_W'(1);
  assign n_last   = n_active - CUR_W'(1);
  assign cur_clip = (cur > CUR_W'(MAX_BINS - 1)) ? CUR_W'(MAX_BINS - 1) : cur;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (sweep == ADDR_LAST) state_next = ST_IDLE;
      ST_IDLE:    if (in_acc) state_next = ST_EVAL;
      ST_EVAL:    if (!step) state_next = ST_WRITE;
      ST_WRITE: begin
        if (ev_last) begin
          state_next = ST_DUMP_RD;
        end else if (in_acc) begin
          state_next = ST_EVAL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DUMP_RD: state_next = ST_DUMP_WR;
      ST_DUMP_WR: begin
        if (emit && !out_free) begin
          state_next = ST_DUMP_WR;
        end else if (sweep == sweep_last) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_DUMP_RD;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = sweep;
    wr_en    = 1'b0;
    wr_addr  = sweep;
    wr_data  = '0;
    out_load = 1'b0;
    unique case (state)
      ST_CLEAR: wr_en = 1'b1;
      ST_IDLE:  s_tready = 1'b1;
      ST_EVAL: begin
        rd_en   = !step && (cur < n_active);
        rd_addr = cur[ADDR_W-1:0];
      end
      ST_WRITE: begin
        s_tready = !ev_last;
        wr_en    = do_inc && (rd_data != COUNT_MAX);
        wr_addr  = cur[ADDR_W-1:0];
        wr_data  = rd_data + COUNT_W'(1);
      end
      ST_DUMP_RD: rd_en = 1'b1;
      ST_DUMP_WR: begin
        wr_en    = 1'b1;                 // zero the bin as it is read out
        out_load = emit && out_free;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- bin RAM
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      bin_width   <= WIDTH_RST;
      bins_in_use <= NBINS_RST;
      cur         <= '0;
      bin_end     <= END_W'(WIDTH_RST);
      dropped     <= 1'b0;
      sweep       <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wr) begin
        if (paddr[2] == REG_BIN_WIDTH) begin
          bin_width <= pwdata;
          bin_end   <= END_W'(pwdata) * END_W'(cur_p1);
        end else begin
          bins_in_use <= pwdata[NBINS_W-1:0];
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: sweep <= sweep + ADDR_W'(1);
        ST_EVAL: begin
          if (step) begin
            cur     <= cur + CUR_W'(1);
            bin_end <= bin_end + END_W'(bin_width);
          end else if (cur >= n_active) begin
            dropped <= 1'b1;
          end
        end
        ST_WRITE: sweep <= '0;
        ST_DUMP_WR: begin
          if (!(emit && !out_free)) begin
            if (sweep == sweep_last) begin
              cur     <= '0;                 // rewind for the next run
              bin_end <= END_W'(bin_width);
              dropped <= 1'b0;
            end else begin
              sweep <= sweep + ADDR_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_time <= s_tdata;
      ev_last <= s_tlast;
    end
    if (state == ST_EVAL && !step) begin
      do_inc <= cur < n_active;
    end
    if (state == ST_WRITE) begin
      // sweep covers the bins in use and any higher bin the pointer reached
      sweep_last <= (cur_clip > n_last) ? cur_clip[ADDR_W-1:0] : n_last[ADDR_W-1:0];
    end
    if (out_load) begin
      out_index <= IDX_W'(sweep);
      out_count <= rd_data;
      out_last  <= (CUR_W'(sweep) == n_last);
      out_drop  <= dropped;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_count, out_index};
  assign m_tlast  = out_last;
  assign m_tuser  = out_drop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BINS_IN_USE) ? CFG_W'(bins_in_use) : bin_width;

  // ---------------------------------------------------------------- checks
  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    cur <= CUR_W'(MAX_BINS))
    else $error("bin pointer past MAX_BINS");

  a_step_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && step && !cfg_wr) |=> bin_end == $past(bin_end) + END_W'($past(bin_width)))
    else $error("bin boundary did not advance by one width");

  a_no_take_in_dump: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP_RD || state == ST_DUMP_WR || state == ST_CLEAR) |-> !s_tready)
    else $error("item taken during readout or clearing");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DUMP_WR)
    else $error("result raised outside readout");

  a_rewind: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP_WR && state_next == ST_IDLE) |=> (cur == '0 && !dropped))
    else $error("run not rewound after readout");

endmodule
